### design/bkr_pkg.sv
// Shared constants and types of the bridge ratio front end with its scalar Kalman filter.
// Used by the register block and the top level; depends on nothing else.
`default_nettype none

package bkr_pkg;

  // Field widths.
  localparam int RAW_W       = 12;
  localparam int N_CH        = 4;
  localparam int SCALE_W     = 20;
  localparam int NOISE_W     = 24;
  localparam int COV_W       = 24;
  localparam int MV_W        = 34;
  localparam int RATIO_W     = 32;
  localparam int RATIO_FRAC  = 24;

  // Default parameter values.
  localparam int ADC_BITS_DEF  = 12;
  localparam int FRAC_BITS_DEF = 16;

  // Stream payload widths.
  localparam int IN_TDATA_W  = N_CH * RAW_W;
  localparam int OUT_BITS    = 3 * MV_W + RATIO_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;

  // Register reset values.
  localparam logic [SCALE_W-1:0]    RST_MV_PER_COUNT = 20'd52429;
  localparam logic [NOISE_W-1:0]    RST_PROC_NOISE   = 24'd66;
  localparam logic [NOISE_W-1:0]    RST_MEAS_NOISE   = 24'd6554;
  localparam logic signed [MV_W-1:0] RST_INIT_EST    = 34'sd196608;
  localparam logic [COV_W-1:0]      RST_INIT_COV     = 24'd65536;

  // Ratio saturation limits.
  localparam logic [RATIO_W-1:0] RATIO_MAX = {1'b0, {(RATIO_W-1){1'b1}}};
  localparam logic [RATIO_W-1:0] RATIO_MIN = {1'b1, {(RATIO_W-1){1'b0}}};

  // Register contents handed from the configuration port to the datapath.
  typedef struct packed {
    logic [SCALE_W-1:0]     mv_per_count;
    logic [NOISE_W-1:0]     process_noise;
    logic [NOISE_W-1:0]     measurement_noise;
    logic signed [MV_W-1:0] initial_estimate;
    logic [COV_W-1:0]       initial_covariance;
  } cfg_t;

endpackage

`default_nettype wire

### design/bkr_shift_mul.sv
// Bit-serial signed-by-unsigned multiplier, one multiplier bit per cycle, MSB first.
// Stand-alone; used by the bridge ratio top level for scaling and the filter update.
`default_nettype none

module bkr_shift_mul #(
  parameter int AW = 21,
  parameter int BW = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [AW-1:0] a,
  input  wire logic [BW-1:0]        b,
  output logic                      busy,
  output logic signed [AW+BW-1:0]   prod
);

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic [CW-1:0]        cnt;
  logic signed [AW-1:0] a_r;
  logic [BW-1:0]        b_sh;
  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] a_ext;
  logic signed [PW-1:0] acc_next;

  // Double the running sum and add the multiplicand when the next bit is set.
  assign a_ext    = PW'(a_r);
  assign acc_next = (acc <<< 1) + (b_sh[BW-1] ? a_ext : '0);
  assign prod     = acc;

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(BW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_sh <= b;
      acc  <= '0;
    end else if (busy) begin
      acc  <= acc_next;
      b_sh <= b_sh << 1;
    end
  end

endmodule

`default_nettype wire

### design/bkr_shift_div.sv
// Restoring divider that yields one quotient bit per cycle.
// Stand-alone; the caller ensures the starting remainder is below the divisor.
`default_nettype none

module bkr_shift_div #(
  parameter int RW = 26,
  parameter int NQ = 17
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [RW-1:0] rem_init,
  input  wire logic [NQ-1:0] low,
  input  wire logic [RW-1:0] divisor,
  output logic               busy,
  output logic [NQ-1:0]      quot
);

  localparam int CW = $clog2(NQ + 1);

  logic [CW-1:0] cnt;
  logic [RW-1:0] rem;
  logic [RW-1:0] dv;
  logic [NQ-1:0] low_sh;
  logic [RW:0]   rem2;
  logic [RW:0]   diff;
  logic          ge;

  // Bring down the next dividend bit and trial-subtract the divisor.
  assign rem2 = {rem, low_sh[NQ-1]};
  assign ge   = rem2 >= {1'b0, dv};
  assign diff = rem2 - {1'b0, dv};

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NQ);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= rem_init;
      dv     <= divisor;
      low_sh <= low;
      quot   <= '0;
    end else if (busy) begin
      rem    <= ge ? diff[RW-1:0] : rem2[RW-1:0];
      low_sh <= low_sh << 1;
      quot   <= {quot[NQ-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### design/bkr_regs.sv
// Configuration registers behind a simple APB-style port, 64-bit data, 8-byte stride.
// Depends on bkr_pkg for widths, reset values and the register struct.
`default_nettype none

module bkr_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bkr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [bkr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [bkr_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready,
  output bkr_pkg::cfg_t                         cfg
);

  import bkr_pkg::*;

  localparam logic [2:0] REG_MV_PER_COUNT = 3'd0;
  localparam logic [2:0] REG_PROC_NOISE   = 3'd1;
  localparam logic [2:0] REG_MEAS_NOISE   = 3'd2;
  localparam logic [2:0] REG_INIT_EST     = 3'd3;
  localparam logic [2:0] REG_INIT_COV     = 3'd4;

  logic [2:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_ADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mv_per_count       <= RST_MV_PER_COUNT;
      cfg.process_noise      <= RST_PROC_NOISE;
      cfg.measurement_noise  <= RST_MEAS_NOISE;
      cfg.initial_estimate   <= RST_INIT_EST;
      cfg.initial_covariance <= RST_INIT_COV;
    end else if (wr_en) begin
      unique case (idx)
        REG_MV_PER_COUNT: cfg.mv_per_count       <= pwdata[SCALE_W-1:0];
        REG_PROC_NOISE:   cfg.process_noise      <= pwdata[NOISE_W-1:0];
        REG_MEAS_NOISE:   cfg.measurement_noise  <= pwdata[NOISE_W-1:0];
        REG_INIT_EST:     cfg.initial_estimate   <= signed'(pwdata[MV_W-1:0]);
        REG_INIT_COV:     cfg.initial_covariance <= pwdata[COV_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (idx)
      REG_MV_PER_COUNT: prdata = CFG_DATA_W'(cfg.mv_per_count);
      REG_PROC_NOISE:   prdata = CFG_DATA_W'(cfg.process_noise);
      REG_MEAS_NOISE:   prdata = CFG_DATA_W'(cfg.measurement_noise);
      REG_INIT_EST:     prdata = CFG_DATA_W'(cfg.initial_estimate);
      REG_INIT_COV:     prdata = CFG_DATA_W'(cfg.initial_covariance);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/bridge_kalman_ratio.sv
// Each accepted item passes through channel scaling alongside the gain division, then the
// filter multiply, the ratio division and the output step; the gain division and the filter
// multiply each work on FRAC_BITS + 1 bits and the ratio divider on 32 bits. A new item is
// accepted only when idle; a finished result waits in the output register during the next item.
// Reset (synchronous, active high) loads register defaults and the initial estimate and
// covariance; there is no clearing pass.
`default_nettype none

module bridge_kalman_ratio #(
  parameter int ADC_BITS  = bkr_pkg::ADC_BITS_DEF,
  parameter int FRAC_BITS = bkr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input item: raw_ref_pos, raw_ref_neg, raw_out_neg, raw_out_pos (from bit 0 up).
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [bkr_pkg::IN_TDATA_W-1:0]   s_tdata,
  // Result item: reference_mv, output_mv, filtered_mv, balance_ratio, zero padding.
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [bkr_pkg::OUT_TDATA_W-1:0]       m_tdata,
  // Result flag: ratio_invalid.
  output logic                                  m_tuser,
  // Configuration port.
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bkr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [bkr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [bkr_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready
);

  import bkr_pkg::*;

  localparam int RAW_USE  = (ADC_BITS < RAW_W) ? ADC_BITS : RAW_W;
  localparam int KW       = FRAC_BITS + 1;
  localparam int SMUL_AW  = SCALE_W + 1;
  localparam int SMUL_PW  = SMUL_AW + RAW_USE;
  localparam int PPRE_W   = COV_W + 1;
  localparam int S_W      = COV_W + 2;
  localparam int Y_W      = MV_W + 1;
  localparam int KY_W     = Y_W + KW;
  localparam int DELTA_W  = KY_W - FRAC_BITS;
  localparam int SUM_W    = MV_W + 3;
  localparam int CP_W     = S_W + KW;
  localparam int PN_W     = CP_W - FRAC_BITS;
  localparam int OVF_SH   = RATIO_W - RATIO_FRAC;

  localparam logic [KW-1:0]        K_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [MV_W-1:0]      EST_MAX = {1'b0, {(MV_W-1){1'b1}}};
  localparam logic [MV_W-1:0]      EST_MIN = {1'b1, {(MV_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_MUL_START,
    ST_MUL,
    ST_DIV_START,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t state;
  cfg_t   cfg;

  logic accept;

  // Filter state and per-item registers.
  logic signed [MV_W-1:0] estimate;
  logic [COV_W-1:0]       covariance;
  logic signed [MV_W-1:0] vref_r;
  logic signed [MV_W-1:0] vout_r;
  logic                   s_zero;
  logic [RATIO_W-1:0]     ratio_r;
  logic                   inv_r;

  // Configuration registers.
  bkr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Channel scaling: four serial multipliers run side by side on the raw counts.
  logic [RAW_W-1:0]          raw_ch     [N_CH];
  logic signed [SMUL_PW-1:0] scale_prod [N_CH];
  logic signed [MV_W-1:0]    scaled     [N_CH];
  logic [N_CH-1:0]           scale_busy;
  logic signed [SMUL_AW-1:0] mv_s;

  assign mv_s = signed'({1'b0, cfg.mv_per_count});

  for (genvar ch = 0; ch < N_CH; ch++) begin : g_scale
    assign raw_ch[ch] = s_tdata[ch*RAW_W +: RAW_W];
    // The product of a 12-bit count and a 20-bit scale never reaches the 34-bit limit.
    assign scaled[ch] = signed'({{(MV_W-SMUL_PW){1'b0}}, scale_prod[ch]});

    bkr_shift_mul #(
      .AW (SMUL_AW),
      .BW (RAW_USE)
    ) u_scale (
      .clk   (clk),
      .rst   (rst),
      .start (accept),
      .a     (mv_s),
      .b     (raw_ch[ch][RAW_USE-1:0]),
      .busy  (scale_busy[ch]),
      .prod  (scale_prod[ch])
    );
  end

  // Kalman gain K = (P_pre << FRAC_BITS) / S, computed while the counts are scaled.
  logic [PPRE_W-1:0] p_pre;
  logic [S_W-1:0]    s_sum;
  logic [KW-1:0]     kdiv_q;
  logic              kdiv_busy;
  logic [KW-1:0]     k_val;
  logic [KW-1:0]     one_minus_k;

  assign p_pre = {1'b0, covariance} + {1'b0, cfg.process_noise};
  assign s_sum = {1'b0, p_pre} + {2'b0, cfg.measurement_noise};

  bkr_shift_div #(
    .RW (S_W),
    .NQ (KW)
  ) u_kdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .rem_init ({2'b0, p_pre[PPRE_W-1:1]}),
    .low      ({p_pre[0], {FRAC_BITS{1'b0}}}),
    .divisor  (s_sum),
    .busy     (kdiv_busy),
    .quot     (kdiv_q)
  );

  // Since P_pre never exceeds S the quotient is at most one; a zero S gives no gain.
  assign k_val       = s_zero ? '0 : kdiv_q;
  assign one_minus_k = K_ONE - k_val;

  // Filter update products K * y and (1 - K) * P_pre.
  logic signed [Y_W-1:0]  y_val;
  logic signed [KY_W-1:0] ky_prod;
  logic                   ky_busy;
  logic signed [CP_W-1:0] cov_prod;
  logic                   cov_busy;
  logic                   mul_start;

  assign y_val     = Y_W'(vout_r) - Y_W'(estimate);
  assign mul_start = (state == ST_MUL_START);

  bkr_shift_mul #(
    .AW (Y_W),
    .BW (KW)
  ) u_ky_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (y_val),
    .b     (k_val),
    .busy  (ky_busy),
    .prod  (ky_prod)
  );

  bkr_shift_mul #(
    .AW (S_W),
    .BW (KW)
  ) u_cov_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (signed'({1'b0, p_pre})),
    .b     (one_minus_k),
    .busy  (cov_busy),
    .prod  (cov_prod)
  );

  // New estimate: floor shift of K * y, added and clamped to 34 bits signed.
  logic signed [DELTA_W-1:0] ky_delta;
  logic signed [SUM_W-1:0]   est_sum;
  logic                      sat_hi;
  logic                      sat_lo;
  logic signed [MV_W-1:0]    est_new;
  logic [PN_W-1:0]           pn;
  logic [COV_W-1:0]          cov_new;

  assign ky_delta = signed'(ky_prod[KY_W-1:FRAC_BITS]);
  assign est_sum  = SUM_W'(estimate) + SUM_W'(ky_delta);
  assign sat_hi   = !est_sum[SUM_W-1] && (|est_sum[SUM_W-2:MV_W-1]);
  assign sat_lo   = est_sum[SUM_W-1] && !(&est_sum[SUM_W-2:MV_W-1]);
  assign est_new  = sat_hi ? signed'(EST_MAX) :
                    sat_lo ? signed'(EST_MIN) : est_sum[MV_W-1:0];

  // New covariance, saturated to 24 bits.
  assign pn      = cov_prod[CP_W-1:FRAC_BITS];
  assign cov_new = (|pn[PN_W-1:COV_W]) ? '1 : pn[COV_W-1:0];

  // Ratio division on magnitudes: (|estimate| << 24) / |reference|.
  logic [MV_W-1:0]    est_mag;
  logic [MV_W-1:0]    ref_mag;
  logic [MV_W-1:0]    est_hi;
  logic               ref_zero;
  logic               ratio_neg;
  logic               ratio_ovf;
  logic [RATIO_W-1:0] rdiv_q;
  logic               rdiv_busy;

  assign est_mag   = estimate[MV_W-1] ? MV_W'(-estimate) : MV_W'(estimate);
  assign ref_mag   = vref_r[MV_W-1] ? MV_W'(-vref_r) : MV_W'(vref_r);
  assign est_hi    = MV_W'(est_mag[MV_W-1:OVF_SH]);
  assign ref_zero  = (vref_r == '0);
  assign ratio_neg = estimate[MV_W-1] ^ vref_r[MV_W-1];
  // A quotient of 2^32 or more is caught before the divider runs.
  assign ratio_ovf = est_hi >= ref_mag;

  bkr_shift_div #(
    .RW (MV_W),
    .NQ (RATIO_W)
  ) u_rdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DIV_START),
    .rem_init (est_hi),
    .low      ({est_mag[OVF_SH-1:0], {RATIO_FRAC{1'b0}}}),
    .divisor  (ref_mag),
    .busy     (rdiv_busy),
    .quot     (rdiv_q)
  );

  // Signed ratio with saturation and the invalid flag.
  logic [RATIO_W-1:0] ratio_next;
  logic               inv_next;

  always_comb begin
    if (ref_zero) begin
      ratio_next = estimate[MV_W-1] ? RATIO_MIN : RATIO_MAX;
      inv_next   = 1'b1;
    end else if (ratio_ovf || (!ratio_neg && rdiv_q[RATIO_W-1]) ||
                 (ratio_neg && rdiv_q[RATIO_W-1] && (|rdiv_q[RATIO_W-2:0]))) begin
      ratio_next = ratio_neg ? RATIO_MIN : RATIO_MAX;
      inv_next   = 1'b1;
    end else begin
      ratio_next = ratio_neg ? (~rdiv_q + 1'b1) : rdiv_q;
      inv_next   = 1'b0;
    end
  end

  // Sequencer, filter state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      m_tvalid   <= 1'b0;
      estimate   <= RST_INIT_EST;
      covariance <= RST_INIT_COV;
    end else begin
      // The output step reloads the register itself when the waiting item leaves.
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            s_zero <= (s_sum == '0);
            state  <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if ((scale_busy == '0) && !kdiv_busy) begin
            vref_r <= scaled[0] - scaled[1];
            vout_r <= scaled[3] - scaled[2];
            state  <= ST_MUL_START;
          end
        end
        ST_MUL_START: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (!ky_busy && !cov_busy) begin
            estimate   <= est_new;
            covariance <= cov_new;
            state      <= ST_DIV_START;
          end
        end
        ST_DIV_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (!rdiv_busy) begin
            ratio_r <= ratio_next;
            inv_r   <= inv_next;
            state   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(OUT_TDATA_W-OUT_BITS){1'b0}}, ratio_r, estimate, vout_r, vref_r};
            m_tuser  <= inv_r;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted item starts the gain division and the scaling together.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (kdiv_busy && scale_busy[0]))
    else $error("accepted item did not start the serial units");

  // The filter multiply starts only after scaling and the gain are complete.
  a_mul_operands_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL_START) |-> (!kdiv_busy && (scale_busy == '0)))
    else $error("filter multiply started with operands still in progress");

  // A new result appears only from the output step of the sequencer.
  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_OUT))
    else $error("result raised outside the output step");

  // Neither filter multiplier nor the ratio divider is still running while the block waits for an item.
  a_idle_units_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!ky_busy && !cov_busy && !rdiv_busy))
    else $error("serial unit busy while idle");
`endif

endmodule

`default_nettype wire
